FILE: hw/rtl/rhsn_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and packing helpers for the ray hit surface normal block.
// Depends on nothing; every other file of the block imports it.
package rhsn_pkg;

    localparam int CW     = 21;            // coordinate width, signed Q10.10
    localparam int FRAC   = 10;
    localparam int UNIT   = 1 << FRAC;
    localparam int PKT_W  = 63;            // packed three-coordinate field
    localparam int DIST_W = 21;
    localparam int KIND_W = 2;

    localparam int W_W    = CW + 1;        // hit point minus entity position
    localparam int NV_W   = 32;            // normalizer input component
    localparam int MAG_W  = NV_W;
    localparam int SQ_W   = 64;            // squared length
    localparam int SH_W   = 6;             // even prescale shift, 0 to 60
    localparam int LEN_W  = SQ_W / 2;      // integer square root
    localparam int QB     = FRAC + 1;      // quotient bits, quotient stays below 2048
    localparam int DIV_W  = 45;
    localparam int NO_W   = FRAC + 2;      // unit component in [-1024, 1024]

    localparam int ISQ_STEPS = SQ_W / 2;
    localparam int HIT_LAT   = 3;
    localparam int NORM_LAT  = 5 + ISQ_STEPS + 1 + QB + 1;

    typedef enum logic [KIND_W-1:0] {
        KIND_SPHERE   = 2'd0,
        KIND_PLANE    = 2'd1,
        KIND_CYLINDER = 2'd2,
        KIND_DISK     = 2'd3
    } kind_t;

    typedef logic signed [CW-1:0]   coord_t;
    typedef logic signed [W_W-1:0]  wcomp_t;
    typedef logic signed [NV_W-1:0] ncomp_t;
    typedef logic signed [NO_W-1:0] ucomp_t;
    typedef logic [DIV_W-1:0]       dval_t;
    typedef logic [QB-1:0]          quo_t;

    function automatic coord_t coord_get(input logic [PKT_W-1:0] p, input int i);
        coord_get = p[i*CW +: CW];
    endfunction

    function automatic logic [PKT_W-1:0] coord_pack(input coord_t c0, input coord_t c1,
                                                    input coord_t c2);
        logic [PKT_W-1:0] r;
        r = '0;
        r[0 +: CW]    = c0;
        r[CW +: CW]   = c1;
        r[2*CW +: CW] = c2;
        coord_pack = r;
    endfunction

endpackage

FILE: hw/rtl/rhsn_hit.sv
`timescale 1ns / 1ps
// Hit point pipeline: origin plus direction times distance, rounded and saturated,
// and the offset of the hit point from the entity position. Uses rhsn_pkg.
module rhsn_hit (
    input  logic                          aclk,
    input  logic                          en,
    input  rhsn_pkg::coord_t              org [3],
    input  rhsn_pkg::coord_t              dir [3],
    input  rhsn_pkg::coord_t              pos [3],
    input  logic [rhsn_pkg::DIST_W-1:0]   dist_in,
    output rhsn_pkg::coord_t              hit [3],
    output rhsn_pkg::wcomp_t              w [3]
);
    import rhsn_pkg::*;

    localparam int PW = CW + DIST_W + 1;
    localparam logic signed [PW:0] HI_V = (PW+1)'(2**(CW-1) - 1);
    localparam logic signed [PW:0] LO_V = -HI_V - 1;

    logic signed [PW-1:0] prod_reg [3];
    coord_t org_reg [3];
    coord_t pos1_reg [3];
    coord_t pos2_reg [3];
    coord_t sat_reg [3];
    coord_t hit_reg [3];
    wcomp_t w_reg [3];
    coord_t sat_next [3];

    always_comb begin
        logic signed [PW:0] rsum;
        logic signed [PW:0] tot;
        for (int i = 0; i < 3; i++) begin
            rsum = (PW+1)'(prod_reg[i]) + (PW+1)'(UNIT / 2);
            tot  = (rsum >>> FRAC) + (PW+1)'(org_reg[i]);
            if (tot > HI_V) begin
                sat_next[i] = CW'(HI_V);
            end else if (tot < LO_V) begin
                sat_next[i] = CW'(LO_V);
            end else begin
                sat_next[i] = CW'(tot);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                prod_reg[i] <= PW'(dir[i]) * PW'($signed({1'b0, dist_in}));
                org_reg[i]  <= org[i];
                pos1_reg[i] <= pos[i];
                sat_reg[i]  <= sat_next[i];
                pos2_reg[i] <= pos1_reg[i];
                hit_reg[i]  <= sat_reg[i];
                w_reg[i]    <= W_W'(sat_reg[i]) - W_W'(pos2_reg[i]);
            end
        end
    end

    assign hit = hit_reg;
    assign w   = w_reg;

endmodule

FILE: hw/rtl/rhsn_isqrt.sv
`timescale 1ns / 1ps
// Pipelined integer square root, one result bit per stage, floor result.
// Uses rhsn_pkg.
module rhsn_isqrt (
    input  logic                         aclk,
    input  logic                         en,
    input  logic [rhsn_pkg::SQ_W-1:0]    radicand,
    output logic [rhsn_pkg::LEN_W-1:0]   root
);
    import rhsn_pkg::*;

    logic [SQ_W-1:0] rem_reg [ISQ_STEPS];
    logic [SQ_W-1:0] res_reg [ISQ_STEPS];
    logic [SQ_W-1:0] rem_in [ISQ_STEPS];
    logic [SQ_W-1:0] res_in [ISQ_STEPS];
    logic [SQ_W-1:0] rem_next [ISQ_STEPS];
    logic [SQ_W-1:0] res_next [ISQ_STEPS];

    always_comb begin
        logic [SQ_W-1:0] bit_v;
        logic [SQ_W-1:0] trial;
        rem_in[0] = radicand;
        res_in[0] = '0;
        for (int j = 1; j < ISQ_STEPS; j++) begin
            rem_in[j] = rem_reg[j-1];
            res_in[j] = res_reg[j-1];
        end
        for (int j = 0; j < ISQ_STEPS; j++) begin
            bit_v = SQ_W'(1) << (2 * (ISQ_STEPS - 1 - j));
            trial = res_in[j] + bit_v;
            if (rem_in[j] >= trial) begin
                rem_next[j] = rem_in[j] - trial;
                res_next[j] = (res_in[j] >> 1) + bit_v;
            end else begin
                rem_next[j] = rem_in[j];
                res_next[j] = res_in[j] >> 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg <= rem_next;
            res_reg <= res_next;
        end
    end

    assign root = res_reg[ISQ_STEPS-1][LEN_W-1:0];

endmodule

FILE: hw/rtl/rhsn_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider for three dividends over one shared divisor,
// one quotient bit per stage. Uses rhsn_pkg.
module rhsn_div (
    input  logic              aclk,
    input  logic              en,
    input  rhsn_pkg::dval_t   dividend [3],
    input  rhsn_pkg::dval_t   divisor,
    output rhsn_pkg::quo_t    quo [3]
);
    import rhsn_pkg::*;

    dval_t rem_reg [QB][3];
    quo_t  quo_reg [QB][3];
    dval_t den_reg [QB];
    dval_t rem_in [QB][3];
    quo_t  quo_in [QB][3];
    dval_t den_in [QB];
    dval_t rem_next [QB][3];
    quo_t  quo_next [QB][3];

    always_comb begin
        dval_t trial;
        den_in[0] = divisor;
        for (int i = 0; i < 3; i++) begin
            rem_in[0][i] = dividend[i];
            quo_in[0][i] = '0;
        end
        for (int j = 1; j < QB; j++) begin
            den_in[j] = den_reg[j-1];
            rem_in[j] = rem_reg[j-1];
            quo_in[j] = quo_reg[j-1];
        end
        for (int j = 0; j < QB; j++) begin
            trial = den_in[j] << (QB - 1 - j);
            for (int i = 0; i < 3; i++) begin
                if (rem_in[j][i] >= trial) begin
                    rem_next[j][i] = rem_in[j][i] - trial;
                    quo_next[j][i] = {quo_in[j][i][QB-2:0], 1'b1};
                end else begin
                    rem_next[j][i] = rem_in[j][i];
                    quo_next[j][i] = {quo_in[j][i][QB-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            den_reg <= den_in;
        end
    end

    assign quo = quo_reg[QB-1];

endmodule

FILE: hw/rtl/rhsn_norm.sv
`timescale 1ns / 1ps
// Vector normalizer: squared length, even prescale, square root and division
// to a signed Q1.10 unit vector. Uses rhsn_pkg, rhsn_isqrt and rhsn_div.
module rhsn_norm (
    input  logic              aclk,
    input  logic              en,
    input  rhsn_pkg::ncomp_t  vin [3],
    output rhsn_pkg::ucomp_t  vout [3]
);
    import rhsn_pkg::*;

    localparam int P_ROOT = 5 + ISQ_STEPS;
    localparam int P_PREP = P_ROOT + 1;
    localparam int P_QUO  = P_PREP + QB;
    localparam int S_MAX  = SQ_W - 4;
    localparam int NUM_W  = MAG_W + FRAC + S_MAX / 2 + 1;

    logic [MAG_W-1:0] mag_reg [1:P_ROOT][3];
    logic             sgn_reg [1:P_QUO][3];
    logic             zero_reg [3:P_QUO];
    logic [SH_W-1:0]  s_reg [4:P_ROOT];
    logic [SQ_W-1:0]  sq_reg [3];
    logic [SQ_W-1:0]  sum_reg;
    logic [SQ_W-1:0]  sum4_reg;
    logic [SQ_W-1:0]  n_reg;
    dval_t            dnd_reg [3];
    dval_t            den_reg;
    ucomp_t           out_reg [3];

    logic [SQ_W-1:0]  sum_next;
    logic [SH_W-1:0]  s_next;
    logic [LEN_W-1:0] root;
    dval_t            dnd_next [3];
    quo_t             quo [3];

    assign sum_next = sq_reg[0] + sq_reg[1] + sq_reg[2];

    // Largest even shift that keeps the scaled square below 2^62.
    always_comb begin
        s_next = '0;
        for (int k = 0; k <= S_MAX / 2; k++) begin
            if ((sum_reg >> (SQ_W - 2 - 2 * k)) == '0) begin
                s_next = SH_W'(2 * k);
            end
        end
    end

    always_comb begin
        logic [NUM_W-1:0] numw;
        for (int i = 0; i < 3; i++) begin
            numw = NUM_W'(mag_reg[P_ROOT][i]) << (FRAC + int'(s_reg[P_ROOT][SH_W-1:1]));
            dnd_next[i] = DIV_W'({numw, 1'b0}) + DIV_W'(root);
        end
    end

    rhsn_isqrt u_isqrt (
        .aclk     (aclk),
        .en       (en),
        .radicand (n_reg),
        .root     (root)
    );

    rhsn_div u_div (
        .aclk     (aclk),
        .en       (en),
        .dividend (dnd_reg),
        .divisor  (den_reg),
        .quo      (quo)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                mag_reg[1][i] <= MAG_W'(vin[i][NV_W-1] ? -vin[i] : vin[i]);
                sgn_reg[1][i] <= vin[i][NV_W-1];
                sq_reg[i]     <= SQ_W'(mag_reg[1][i]) * SQ_W'(mag_reg[1][i]);
            end
            for (int j = 2; j <= P_ROOT; j++) begin
                mag_reg[j] <= mag_reg[j-1];
            end
            for (int j = 2; j <= P_QUO; j++) begin
                sgn_reg[j] <= sgn_reg[j-1];
            end
            sum_reg     <= sum_next;
            zero_reg[3] <= (sum_next == '0);
            for (int j = 4; j <= P_QUO; j++) begin
                zero_reg[j] <= zero_reg[j-1];
            end
            sum4_reg <= sum_reg;
            s_reg[4] <= s_next;
            for (int j = 5; j <= P_ROOT; j++) begin
                s_reg[j] <= s_reg[j-1];
            end
            n_reg   <= sum4_reg << s_reg[4];
            dnd_reg <= dnd_next;
            den_reg <= DIV_W'({root, 1'b0});
            for (int i = 0; i < 3; i++) begin
                if (zero_reg[P_QUO]) begin
                    out_reg[i] <= '0;
                end else if (quo[i] > QB'(UNIT)) begin
                    out_reg[i] <= sgn_reg[P_QUO][i] ? -NO_W'(UNIT) : NO_W'(UNIT);
                end else begin
                    out_reg[i] <= sgn_reg[P_QUO][i] ? -NO_W'(quo[i]) : NO_W'(quo[i]);
                end
            end
        end
    end

    assign vout = out_reg;

endmodule

FILE: hw/rtl/ray_hit_surface_normal.sv
`timescale 1ns / 1ps
// Top level of the ray hit surface normal block: hit point and unit normal.
// Uses rhsn_pkg, rhsn_hit and two rhsn_norm normalizers.
//
// Usage
// The input channel (s_valid, s_ready) takes one beat per hit record: ray origin,
// ray direction, hit distance, entity kind, entity position and entity axis. The
// result channel (m_valid, m_ready) returns one beat per record with the saturated
// hit point and the unit surface normal, both as three packed signed Q10.10 values.
// Records leave in the order they came in.
// The pipeline takes one beat every cycle while it is not stalled. The depth is set
// by the two normalizers in series (axis normalize, then the radial or sphere
// normalize), each with one square root bit and one quotient bit per stage.
// Reset clears all valid bits and the output valid; payload is not cleared.
// When the receiver stalls, the finished beat holds in the output register and the
// pipeline keeps moving as long as its last stage is empty, so bubbles are squeezed
// out; once the last stage holds a beat, all stages freeze together and s_ready
// drops. Nothing is lost or repeated.
module ray_hit_surface_normal (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [rhsn_pkg::PKT_W-1:0]    s_ray_origin,
    input  logic [rhsn_pkg::PKT_W-1:0]    s_ray_direction,
    input  logic [rhsn_pkg::DIST_W-1:0]   s_hit_distance,
    input  logic [rhsn_pkg::KIND_W-1:0]   s_entity_kind,
    input  logic [rhsn_pkg::PKT_W-1:0]    s_entity_position,
    input  logic [rhsn_pkg::PKT_W-1:0]    s_entity_axis,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [rhsn_pkg::PKT_W-1:0]    m_hit_point,
    output logic [rhsn_pkg::PKT_W-1:0]    m_surface_normal
);
    import rhsn_pkg::*;

    // Stage numbers count register stages after acceptance.
    localparam int ST_W   = 1 + HIT_LAT;          // hit point and offset ready
    localparam int ST_A   = 1 + NORM_LAT;         // normalized axis ready
    localparam int ST_CYL = ST_A + 4;             // vector for the second normalizer
    localparam int ST_F   = ST_CYL + NORM_LAT;    // final normal ready

    // Cylinder radial math widths.
    localparam int PW1     = W_W + NO_W;
    localparam int DW      = PW1 + 2;
    localparam int AD_W    = NO_W + DW;
    localparam int RD_W    = AD_W + 1;
    localparam int RAD_UP  = 2 * FRAC;
    localparam int RAD_DN  = FRAC + 2;
    localparam int PD_W    = NO_W + CW;
    localparam int PS_W    = PD_W + 2;

    logic   en;
    logic   out_free;

    logic   vld_reg [1:ST_F];
    kind_t  kind_reg [1:ST_F];
    coord_t org1_reg [3];
    coord_t pos1_reg [3];
    coord_t axis1_reg [3];
    logic [DIST_W-1:0] dist1_reg;
    coord_t dir_d_reg [1:ST_A][3];
    coord_t hit_d_reg [ST_W+1:ST_F][3];
    wcomp_t w_d_reg [ST_W+1:ST_A+3][3];
    ucomp_t a_d_reg [ST_A+1:ST_A+2][3];
    ucomp_t pn_reg [ST_A+3:ST_F][3];

    logic signed [PW1-1:0]  pw_reg [3];
    logic signed [DW-1:0]   dwa_reg;
    logic signed [AD_W-1:0] ad_reg [3];
    logic signed [PD_W-1:0] pd_reg [3];
    logic signed [PS_W-1:0] dsum_reg;
    ncomp_t vec_reg [3];

    logic   m_valid_reg;
    logic [PKT_W-1:0] m_hit_reg;
    logic [PKT_W-1:0] m_nrm_reg;

    coord_t hit_w [3];
    wcomp_t w_w [3];
    ncomp_t axis_n [3];
    ucomp_t a_norm [3];
    ucomp_t f_norm [3];
    ncomp_t vec_next [3];
    ucomp_t pn_next [3];
    ucomp_t sel_norm [3];

    // The output register is free when empty or being taken. The pipeline may
    // also advance while the output waits, provided its last stage is empty.
    assign out_free = !m_valid_reg || m_ready;
    assign en       = out_free || !vld_reg[ST_F];
    assign s_ready  = en;
    assign m_valid  = m_valid_reg;
    assign m_hit_point      = m_hit_reg;
    assign m_surface_normal = m_nrm_reg;

    rhsn_hit u_hit (
        .aclk    (aclk),
        .en      (en),
        .org     (org1_reg),
        .dir     (dir_d_reg[1]),
        .pos     (pos1_reg),
        .dist_in (dist1_reg),
        .hit     (hit_w),
        .w       (w_w)
    );

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            axis_n[i] = NV_W'(axis1_reg[i]);
        end
    end

    rhsn_norm u_norm_axis (
        .aclk (aclk),
        .en   (en),
        .vin  (axis_n),
        .vout (a_norm)
    );

    // Radial vector of a cylinder: offset scaled up by 2^20 minus the axis times
    // the offset's projection on the axis, rounded back down by 2^12. A sphere
    // takes the offset itself.
    always_comb begin
        logic signed [RD_W-1:0] diff;
        for (int i = 0; i < 3; i++) begin
            diff = (RD_W'(w_d_reg[ST_A+3][i]) <<< RAD_UP) - RD_W'(ad_reg[i])
                 + RD_W'(2 ** (RAD_DN - 1));
            if (kind_reg[ST_A+3] == KIND_CYLINDER) begin
                vec_next[i] = NV_W'(diff >>> RAD_DN);
            end else begin
                vec_next[i] = NV_W'(w_d_reg[ST_A+3][i]);
            end
            // Plane and disk normals turn to face the incoming ray.
            pn_next[i] = (dsum_reg > 0) ? -a_d_reg[ST_A+2][i] : a_d_reg[ST_A+2][i];
        end
    end

    rhsn_norm u_norm_final (
        .aclk (aclk),
        .en   (en),
        .vin  (vec_reg),
        .vout (f_norm)
    );

    always_comb begin
        if (kind_reg[ST_F] inside {KIND_PLANE, KIND_DISK}) begin
            sel_norm = pn_reg[ST_F];
        end else begin
            sel_norm = f_norm;
        end
    end

    // Control: valid bits and the output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 1; j <= ST_F; j++) begin
                vld_reg[j] <= 1'b0;
            end
            m_valid_reg <= 1'b0;
        end else begin
            if (en) begin
                vld_reg[1] <= s_valid;
                for (int j = 2; j <= ST_F; j++) begin
                    vld_reg[j] <= vld_reg[j-1];
                end
            end
            if (out_free) begin
                m_valid_reg <= vld_reg[ST_F];
            end
        end
    end

    // Payload pipeline.
    always_ff @(posedge aclk) begin
        if (en) begin
            kind_reg[1] <= kind_t'(s_entity_kind);
            dist1_reg   <= s_hit_distance;
            for (int i = 0; i < 3; i++) begin
                org1_reg[i]     <= coord_get(s_ray_origin, i);
                dir_d_reg[1][i] <= coord_get(s_ray_direction, i);
                pos1_reg[i]     <= coord_get(s_entity_position, i);
                axis1_reg[i]    <= coord_get(s_entity_axis, i);
            end
            for (int j = 2; j <= ST_F; j++) begin
                kind_reg[j] <= kind_reg[j-1];
            end
            for (int j = 2; j <= ST_A; j++) begin
                dir_d_reg[j] <= dir_d_reg[j-1];
            end
            hit_d_reg[ST_W+1] <= hit_w;
            for (int j = ST_W + 2; j <= ST_F; j++) begin
                hit_d_reg[j] <= hit_d_reg[j-1];
            end
            w_d_reg[ST_W+1] <= w_w;
            for (int j = ST_W + 2; j <= ST_A + 3; j++) begin
                w_d_reg[j] <= w_d_reg[j-1];
            end
            a_d_reg[ST_A+1] <= a_norm;
            a_d_reg[ST_A+2] <= a_d_reg[ST_A+1];

            for (int i = 0; i < 3; i++) begin
                pw_reg[i] <= PW1'(w_d_reg[ST_A][i]) * PW1'(a_norm[i]);
                pd_reg[i] <= PD_W'(a_norm[i]) * PD_W'(dir_d_reg[ST_A][i]);
                ad_reg[i] <= AD_W'(a_d_reg[ST_A+2][i]) * AD_W'(dwa_reg);
            end
            dwa_reg  <= DW'(pw_reg[0]) + DW'(pw_reg[1]) + DW'(pw_reg[2]);
            dsum_reg <= PS_W'(pd_reg[0]) + PS_W'(pd_reg[1]) + PS_W'(pd_reg[2]);
            vec_reg  <= vec_next;

            pn_reg[ST_A+3] <= pn_next;
            for (int j = ST_A + 4; j <= ST_F; j++) begin
                pn_reg[j] <= pn_reg[j-1];
            end
        end
        if (out_free && vld_reg[ST_F]) begin
            m_hit_reg <= coord_pack(hit_d_reg[ST_F][0], hit_d_reg[ST_F][1],
                                    hit_d_reg[ST_F][2]);
            m_nrm_reg <= coord_pack(CW'(sel_norm[0]), CW'(sel_norm[1]), CW'(sel_norm[2]));
        end
    end

endmodule

FILE: hw/rtl/rhsn_checker.sv
`timescale 1ns / 1ps
// Port-level assertions for ray_hit_surface_normal, attached by a bind statement.
// Uses rhsn_pkg.
module rhsn_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [rhsn_pkg::PKT_W-1:0]  m_hit_point,
    input logic [rhsn_pkg::PKT_W-1:0]  m_surface_normal
);
    import rhsn_pkg::*;

    logic nrm_ok;

    always_comb begin
        coord_t comp;
        nrm_ok = 1'b1;
        for (int i = 0; i < 3; i++) begin
            comp = coord_get(m_surface_normal, i);
            if (comp > UNIT || comp < -UNIT) begin
                nrm_ok = 1'b0;
            end
        end
    end

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hit_point) && $stable(m_surface_normal))
        else $error("result beat changed while stalled");

    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without output back pressure");

    a_unit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> nrm_ok)
        else $error("normal component outside unit range");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind ray_hit_surface_normal rhsn_checker u_rhsn_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_hit_point      (m_hit_point),
    .m_surface_normal (m_surface_normal)
);

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for ray_hit_surface_normal: hit point and unit normal per hit record.
// Depends on rhsn_pkg and the block's RTL; needs no files or arguments.
module tb;
    import rhsn_pkg::*;

    // One hit record as it is driven onto the input channel.
    typedef struct {
        logic [PKT_W-1:0]  origin;
        logic [PKT_W-1:0]  direction;
        logic [DIST_W-1:0] distance;
        kind_t             kind;
        logic [PKT_W-1:0]  position;
        logic [PKT_W-1:0]  axis;
    } hit_rec_t;

    // One expected result beat.
    typedef struct {
        logic [PKT_W-1:0] point;
        logic [PKT_W-1:0] normal;
    } hit_res_t;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 200;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [PKT_W-1:0]     s_ray_origin;
    logic [PKT_W-1:0]     s_ray_direction;
    logic [DIST_W-1:0]    s_hit_distance;
    logic [KIND_W-1:0]    s_entity_kind;
    logic [PKT_W-1:0]     s_entity_position;
    logic [PKT_W-1:0]     s_entity_axis;
    logic                 m_valid;
    logic                 m_ready;
    logic [PKT_W-1:0]     m_hit_point;
    logic [PKT_W-1:0]     m_surface_normal;

    ray_hit_surface_normal dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_ray_origin      (s_ray_origin),
        .s_ray_direction   (s_ray_direction),
        .s_hit_distance    (s_hit_distance),
        .s_entity_kind     (s_entity_kind),
        .s_entity_position (s_entity_position),
        .s_entity_axis     (s_entity_axis),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_hit_point       (m_hit_point),
        .m_surface_normal  (m_surface_normal)
    );

    // Records waiting to be driven, and results waiting to be seen, oldest first.
    hit_rec_t pending_recs[$];
    hit_res_t expected_hits[$];

    int  send_idle_pct;      // chance in percent that the sender holds off a cycle
    int  recv_stall_pct;     // chance in percent that the receiver stalls a cycle
    int  quiet_cycles;
    int  error_count;
    bit  stim_done;

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------
    // Predictor. All math is done in 64-bit signed integers, which is wide
    // enough for every product the block forms at a coordinate width of 21.
    // ------------------------------------------------------------------
    function automatic longint coord_of(logic [PKT_W-1:0] p, int i);
        logic signed [CW-1:0] c;
        c = p[i*CW +: CW];
        return longint'(c);
    endfunction

    function automatic logic [PKT_W-1:0] pack_coords(longint v0, longint v1, longint v2);
        logic [PKT_W-1:0] r;
        r = '0;
        r[0 +: CW]    = v0[CW-1:0];
        r[CW +: CW]   = v1[CW-1:0];
        r[2*CW +: CW] = v2[CW-1:0];
        return r;
    endfunction

    // Arithmetic shift right with round half up.
    function automatic longint round_half_up(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // Scales a vector to unit length in Q10.10; a zero vector stays zero.
    function automatic void unit_vector(input longint v[3], output longint n[3]);
        longint unsigned sq, len, m, num, q;
        int s;
        sq = 0;
        for (int i = 0; i < 3; i++) begin
            m  = v[i] < 0 ? -v[i] : v[i];
            sq = sq + m * m;
        end
        if (sq == 0) begin
            n[0] = 0;
            n[1] = 0;
            n[2] = 0;
            return;
        end
        s = 60;
        while (s > 0 && (sq >> (62 - s)) != 0)
            s -= 2;
        len = int_sqrt(sq << s);
        for (int i = 0; i < 3; i++) begin
            m    = v[i] < 0 ? -v[i] : v[i];
            num  = m << (FRAC + s / 2);
            q    = (2 * num + len) / (2 * len);
            if (q > UNIT)
                q = UNIT;
            n[i] = v[i] < 0 ? -longint'(q) : longint'(q);
        end
    endfunction

    function automatic hit_res_t predict_hit(hit_rec_t r);
        hit_res_t res;
        longint lo, hi, dwa, d;
        longint dir[3], hit[3], w[3], axis[3], a[3], rad[3], nrm[3];
        lo = -(longint'(1) << (CW - 1));
        hi = (longint'(1) << (CW - 1)) - 1;
        for (int i = 0; i < 3; i++) begin
            dir[i]  = coord_of(r.direction, i);
            axis[i] = coord_of(r.axis, i);
            hit[i]  = coord_of(r.origin, i)
                    + round_half_up(dir[i] * longint'(r.distance), FRAC);
            if (hit[i] < lo)
                hit[i] = lo;
            if (hit[i] > hi)
                hit[i] = hi;
            w[i] = hit[i] - coord_of(r.position, i);
        end
        case (r.kind)
            KIND_SPHERE: begin
                unit_vector(w, nrm);
            end
            KIND_CYLINDER: begin
                // Radial part of the hit offset: remove its projection on the axis.
                unit_vector(axis, a);
                dwa = w[0] * a[0] + w[1] * a[1] + w[2] * a[2];
                for (int i = 0; i < 3; i++)
                    rad[i] = round_half_up(w[i] * (longint'(1) << 20) - a[i] * dwa, 12);
                unit_vector(rad, nrm);
            end
            default: begin
                // Plane and disk: the axis is flipped to face against the ray.
                unit_vector(axis, nrm);
                d = nrm[0] * dir[0] + nrm[1] * dir[1] + nrm[2] * dir[2];
                if (d > 0)
                    for (int i = 0; i < 3; i++)
                        nrm[i] = -nrm[i];
            end
        endcase
        res.point  = pack_coords(hit[0], hit[1], hit[2]);
        res.normal = pack_coords(nrm[0], nrm[1], nrm[2]);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    function automatic logic [CW-1:0] rand_coord(int mode);
        logic [CW-1:0] c;
        case (mode)
            0: c = CW'($urandom);                                  // full range
            1: c = CW'(int'($urandom_range(0, 4095)) - 2048);      // near origin, +-2.0
            2: c = $urandom_range(0, 1) ? {1'b0, {(CW-1){1'b1}}} : {1'b1, {(CW-1){1'b0}}};
            default: c = CW'(int'($urandom_range(0, 2)) - 1);      // tiny
        endcase
        return c;
    endfunction

    function automatic logic [PKT_W-1:0] rand_vec(int bias);
        int mode;
        mode = bias;
        if (bias < 0)
            mode = $urandom_range(0, 9) < 5 ? 0 : ($urandom_range(0, 9) < 7 ? 1 : 3);
        return {rand_coord(mode), rand_coord(mode), rand_coord(mode)};
    endfunction

    function automatic hit_rec_t make_rec(logic [PKT_W-1:0] o, logic [PKT_W-1:0] d,
                                          logic [DIST_W-1:0] t, kind_t k,
                                          logic [PKT_W-1:0] p, logic [PKT_W-1:0] a);
        hit_rec_t r;
        r.origin    = o;
        r.direction = d;
        r.distance  = t;
        r.kind      = k;
        r.position  = p;
        r.axis      = a;
        return r;
    endfunction

    function automatic hit_rec_t random_rec();
        hit_rec_t r;
        int sel;
        r.origin    = rand_vec(-1);
        r.direction = rand_vec(-1);
        sel = $urandom_range(0, 9);
        r.distance = sel < 2 ? DIST_W'($urandom) :
                     (sel < 8 ? DIST_W'($urandom_range(0, 8191)) :
                      DIST_W'($urandom_range(0, 3)));
        r.kind      = kind_t'($urandom_range(0, 3));
        r.axis      = rand_vec(-1);
        // Often put the entity near the hit point so that the offsets stay meaningful.
        if ($urandom_range(0, 2) == 0) begin
            r.position = rand_vec(-1);
        end else begin
            hit_res_t h;
            h = predict_hit(make_rec(r.origin, r.direction, r.distance, KIND_SPHERE, '0, '0));
            r.position = h.point ^ PKT_W'({rand_coord(3), rand_coord(3), rand_coord(1)});
        end
        if ($urandom_range(0, 19) == 0)
            r.axis = '0;
        return r;
    endfunction

    // Waits until every queued record is sent and every result has arrived.
    task automatic wait_drained();
        while (pending_recs.size() != 0 || expected_hits.size() != 0)
            @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Stimulus: directed records, then four phases of random records with different idle and stall rates.
    // ------------------------------------------------------------------
    initial begin
        logic [PKT_W-1:0] max_v, min_v, x_unit, y_unit;
        max_v  = {3{1'b0, {(CW-1){1'b1}}}};
        min_v  = {3{1'b1, {(CW-1){1'b0}}}};
        x_unit = PKT_W'(UNIT);
        y_unit = PKT_W'(UNIT) << CW;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        stim_done      = 1'b0;

        @(posedge aclk);
        while (!aresetn)
            @(posedge aclk);

        // Every kind with simple geometry, all zeros and all ones.
        pending_recs.push_back(make_rec('0, '0, '0, KIND_SPHERE, '0, '0));
        pending_recs.push_back(make_rec('1, '1, '1, KIND_SPHERE, '1, '1));
        pending_recs.push_back(make_rec('0, x_unit, 21'd2048, KIND_SPHERE, '0, '0));
        pending_recs.push_back(make_rec('0, x_unit, 21'd1024, KIND_PLANE, '0, x_unit));
        pending_recs.push_back(make_rec('0, x_unit, 21'd1024, KIND_PLANE, '0, y_unit));
        pending_recs.push_back(make_rec('0, x_unit, 21'd1024, KIND_DISK, '0, x_unit));
        pending_recs.push_back(make_rec('0, x_unit, 21'd1024, KIND_DISK, '0, '0));
        pending_recs.push_back(make_rec(y_unit, x_unit, 21'd1024, KIND_CYLINDER, '0, x_unit));
        // Zero cylinder axis, and a hit point lying on the cylinder axis.
        pending_recs.push_back(make_rec(y_unit, x_unit, 21'd512, KIND_CYLINDER, '0, '0));
        pending_recs.push_back(make_rec('0, x_unit, 21'd1024, KIND_CYLINDER, '0, x_unit));
        // Saturation of the hit point in both directions, extreme fields.
        pending_recs.push_back(make_rec(max_v, max_v, '1, KIND_SPHERE, min_v, max_v));
        pending_recs.push_back(make_rec(min_v, min_v, '1, KIND_PLANE, max_v, min_v));
        pending_recs.push_back(make_rec(max_v, min_v, '1, KIND_CYLINDER, min_v, max_v));
        pending_recs.push_back(make_rec(min_v, max_v, '1, KIND_DISK, max_v, min_v));
        pending_recs.push_back(make_rec(max_v, max_v, '0, KIND_CYLINDER, min_v, min_v));
        pending_recs.push_back(make_rec(min_v, '0, 21'd1, KIND_SPHERE, max_v, '0));
        // Rounding on a half: direction 1 with distance 512.
        pending_recs.push_back(make_rec('0, {3{21'd1}}, 21'd512, KIND_SPHERE, '0, '0));
        pending_recs.push_back(make_rec('0, {3{21'h1FFFFF}}, 21'd512, KIND_PLANE, '0, '1));
        wait_drained();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
                default: begin send_idle_pct = 17; recv_stall_pct = 17; end
            endcase
            for (int n = 0; n < 258; n++)
                pending_recs.push_back(random_rec());
            wait_drained();
        end
        stim_done = 1'b1;
    end

    // Reset is asserted at the start of the run, never again.
    initial begin
        aresetn = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Driver: presents the oldest pending record and keeps it stable until
    // its beat is accepted. The expected result is queued at acceptance.
    // ------------------------------------------------------------------
    initial begin
        s_valid           = 1'b0;
        s_ray_origin      = '0;
        s_ray_direction   = '0;
        s_hit_distance    = '0;
        s_entity_kind     = '0;
        s_entity_position = '0;
        s_entity_axis     = '0;
        m_ready           = 1'b0;
    end

    always @(posedge aclk) begin
        hit_rec_t r;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                r = pending_recs.pop_front();
                expected_hits.push_back(predict_hit(r));
            end
            if ((!s_valid || s_ready) && pending_recs.size() > (s_valid && s_ready ? 0 : 0)) begin
                // A new beat goes out only when the previous one is gone.
                if (pending_recs.size() != 0 && $urandom_range(1, 100) > send_idle_pct) begin
                    r = pending_recs[0];
                    s_valid           <= 1'b1;
                    s_ray_origin      <= r.origin;
                    s_ray_direction   <= r.direction;
                    s_hit_distance    <= r.distance;
                    s_entity_kind     <= r.kind;
                    s_entity_position <= r.position;
                    s_entity_axis     <= r.axis;
                end else begin
                    s_valid <= 1'b0;
                end
            end else if (!s_valid || s_ready) begin
                s_valid <= 1'b0;
            end
            m_ready <= ($urandom_range(1, 100) > recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: every accepted result beat is checked against the oldest
    // expectation, field by field.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        hit_res_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_hits.size() == 0) begin
                $error("result beat with no record waiting: hit_point %h surface_normal %h",
                       m_hit_point, m_surface_normal);
                error_count++;
            end else begin
                e = expected_hits.pop_front();
                if (m_hit_point !== e.point) begin
                    $error("hit_point expected %h actual %h", e.point, m_hit_point);
                    error_count++;
                end
                if (m_surface_normal !== e.normal) begin
                    $error("surface_normal expected %h actual %h", e.normal, m_surface_normal);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: counts cycles in which neither channel moves a beat.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // End of run: after the last result, let the pipeline settle so that a
    // stray extra beat would still be caught, then report.
    initial begin
        wait (stim_done);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0 && expected_hits.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/rhsn_pkg.sv
hw/rtl/rhsn_hit.sv
hw/rtl/rhsn_isqrt.sv
hw/rtl/rhsn_div.sv
hw/rtl/rhsn_norm.sv
hw/rtl/ray_hit_surface_normal.sv
hw/rtl/rhsn_checker.sv
tb/sv/tb.sv
